[sv/oriented_box_vertex_generator_core_assert.svh]
// Assertion macros for the oriented box vertex generator.
// No dependencies; included by modules that check their own logic.
`ifndef ORIENTED_BOX_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define ORIENTED_BOX_VERTEX_GENERATOR_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define OBVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OBVG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/obvg_pkg.sv]
// Package for the oriented box vertex generator: types, constants, tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package obvg_pkg;
  localparam int unsigned PosFracBitsDef = 16;
  localparam int unsigned NumVerts = 24;
  localparam logic [7:0] HiAlphaRst = 8'd255;
  localparam logic [7:0] DefAlphaRst = 8'd77;
  localparam logic [0:0] RegHiAlpha = 1'b0;
  localparam logic [0:0] RegDefAlpha = 1'b1;
  localparam logic signed [31:0] RLimit = 32'sd1073741824;

  typedef logic signed [31:0] mat_t [3][3];

  // corner sign bits (1 = plus) for vertex number, x in bit 0
  function automatic logic [2:0] vtx_signs(input logic [4:0] v);
    logic [2:0] c;
    unique case (v)
      5'd0, 5'd8, 5'd20:  c = 3'd0;
      5'd1, 5'd12, 5'd23: c = 3'd1;
      5'd2, 5'd15, 5'd19: c = 3'd2;
      5'd3, 5'd11, 5'd16: c = 3'd3;
      5'd4, 5'd9, 5'd21:  c = 3'd4;
      5'd5, 5'd13, 5'd22: c = 3'd5;
      5'd6, 5'd14, 5'd18: c = 3'd6;
      5'd7, 5'd10, 5'd17: c = 3'd7;
      default:            c = 3'd0;
    endcase
    vtx_signs = {c[2], c[1], c[0] ^ c[1]};
  endfunction

  // face axis and direction (1 = negative) for vertex number
  function automatic logic [2:0] vtx_face(input logic [4:0] v);
    logic [2:0] f;
    unique case (v[4:2])
      3'd0: f = {2'd2, 1'b1};
      3'd1: f = {2'd2, 1'b0};
      3'd2: f = {2'd0, 1'b1};
      3'd3: f = {2'd0, 1'b0};
      3'd4: f = {2'd1, 1'b0};
      default: f = {2'd1, 1'b1};
    endcase
    vtx_face = f;
  endfunction
endpackage
`default_nettype wire

[sv/obvg_if.sv]
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface obvg_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/obvg_box_in_t.sv]
// Payload structs for the box and vertex channels.
// Depends on nothing; kept as a package of types.
`timescale 1ns / 1ps
`default_nettype none
package obvg_types_pkg;
  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [30:0]        size_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               selected;
  } box_t;
  typedef struct packed {
    logic [4:0]         vertex_number;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         opacity;
    logic               last;
  } vertex_t;
endpackage
`default_nettype wire

[sv/obvg_matrix.sv]
// Rotation matrix pipeline: quaternion products, then Q28 entries, clamped.
// Depends on obvg_pkg and obvg_types_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obvg_matrix (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire obvg_types_pkg::box_t box_i,
  output obvg_pkg::mat_t          mat_o,
  output obvg_types_pkg::box_t    box_o
);
  // stage A: nine products, Q28
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  obvg_types_pkg::box_t box_a_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= box_i.quat_x * box_i.quat_x;
      yy_q <= box_i.quat_y * box_i.quat_y;
      zz_q <= box_i.quat_z * box_i.quat_z;
      xy_q <= box_i.quat_x * box_i.quat_y;
      xz_q <= box_i.quat_x * box_i.quat_z;
      yz_q <= box_i.quat_y * box_i.quat_z;
      wx_q <= box_i.quat_w * box_i.quat_x;
      wy_q <= box_i.quat_w * box_i.quat_y;
      wz_q <= box_i.quat_w * box_i.quat_z;
      box_a_q <= box_i;
    end
  end

  function automatic logic signed [31:0] clampr(input logic signed [34:0] v);
    if (v > 35'(obvg_pkg::RLimit)) clampr = obvg_pkg::RLimit;
    else if (v < -35'(obvg_pkg::RLimit)) clampr = -obvg_pkg::RLimit;
    else clampr = v[31:0];
  endfunction

  function automatic logic signed [34:0] sx(input logic signed [31:0] v);
    sx = 35'(v);
  endfunction

  localparam logic signed [34:0] One = 35'sd268435456;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_o[0][0] <= clampr(One - 2 * (sx(yy_q) + sx(zz_q)));
      mat_o[0][1] <= clampr(2 * (sx(xy_q) - sx(wz_q)));
      mat_o[0][2] <= clampr(2 * (sx(xz_q) + sx(wy_q)));
      mat_o[1][0] <= clampr(2 * (sx(xy_q) + sx(wz_q)));
      mat_o[1][1] <= clampr(One - 2 * (sx(xx_q) + sx(zz_q)));
      mat_o[1][2] <= clampr(2 * (sx(yz_q) - sx(wx_q)));
      mat_o[2][0] <= clampr(2 * (sx(xz_q) - sx(wy_q)));
      mat_o[2][1] <= clampr(2 * (sx(yz_q) + sx(wx_q)));
      mat_o[2][2] <= clampr(One - 2 * (sx(xx_q) + sx(yy_q)));
      box_o <= box_a_q;
    end
  end
endmodule
`default_nettype wire

[sv/obvg_vertex.sv]
// Vertex pipeline: per-vertex products, sums, rounding, centre add, saturate.
// Depends on obvg_pkg, obvg_types_pkg and the assertion header; stalls via en_i.
`timescale 1ns / 1ps
`default_nettype none
module obvg_vertex (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [4:0]           vnum_i,
  input  wire obvg_pkg::mat_t       mat_i,
  input  wire obvg_types_pkg::box_t box_i,
  input  wire logic [7:0]           hi_alpha_i,
  input  wire logic [7:0]           def_alpha_i,
  output logic                      valid_o,
  output obvg_types_pkg::vertex_t   vtx_o
);
  `include "oriented_box_vertex_generator_core_assert.svh"

  logic [2:0] sgn, face;
  logic signed [31:0] size_s [3];
  assign sgn = obvg_pkg::vtx_signs(vnum_i);
  assign face = obvg_pkg::vtx_face(vnum_i);
  assign size_s[0] = sgn[0] ? 32'(box_i.size_x) : -32'(box_i.size_x);
  assign size_s[1] = sgn[1] ? 32'(box_i.size_y) : -32'(box_i.size_y);
  assign size_s[2] = sgn[2] ? 32'(box_i.size_z) : -32'(box_i.size_z);

  // stage P: nine 32x32 products, normals, colours
  logic               v_p_q, v_s_q, v_o_q;
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] cen_p_q [3], cen_s_q [3];
  logic signed [15:0] nrm_p_q [3], nrm_s_q [3];
  logic [4:0]         vn_p_q, vn_s_q;
  logic [7:0]         r_p_q, g_p_q, a_p_q, r_s_q, g_s_q, a_s_q;
  logic signed [66:0] acc_s_q [3];

  function automatic logic signed [15:0] nrm(input logic signed [31:0] m, input logic neg);
    logic signed [33:0] t;
    logic signed [33:0] r;
    t = neg ? -34'(m) : 34'(m);
    r = (t + 34'sd8192) >>> 14;
    if (r > 34'sd32767) nrm = 16'sh7fff;
    else if (r < -34'sd32768) nrm = 16'sh8000;
    else nrm = r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod_q[i][j] <= mat_i[i][j] * size_s[j];
        nrm_p_q[i] <= nrm(mat_i[i][face[2:1]], face[0]);
      end
      cen_p_q[0] <= box_i.centre_x;
      cen_p_q[1] <= box_i.centre_y;
      cen_p_q[2] <= box_i.centre_z;
      vn_p_q <= vnum_i;
      r_p_q <= box_i.selected ? 8'd255 : 8'd217;
      g_p_q <= box_i.selected ? 8'd217 : 8'd191;
      a_p_q <= box_i.selected ? hi_alpha_i : def_alpha_i;
    end
  end

  // stage S: sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        acc_s_q[i] <= 67'(prod_q[i][0]) + 67'(prod_q[i][1]) + 67'(prod_q[i][2]);
        cen_s_q[i] <= cen_p_q[i];
        nrm_s_q[i] <= nrm_p_q[i];
      end
      vn_s_q <= vn_p_q;
      r_s_q <= r_p_q;
      g_s_q <= g_p_q;
      a_s_q <= a_p_q;
    end
  end

  // stage O: round (arithmetic shift equals floor of half-up), add, saturate
  logic signed [66:0] rnd [3];
  logic signed [38:0] pos [3];
  logic signed [31:0] wrl [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (acc_s_q[i] + 67'sd268435456) >>> 29;
      pos[i] = rnd[i][38:0] + 39'(cen_s_q[i]);
      if (pos[i] > 39'sd2147483647) wrl[i] = 32'sh7fffffff;
      else if (pos[i] < -39'sd2147483648) wrl[i] = 32'sh80000000;
      else wrl[i] = pos[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_o.vertex_number <= vn_s_q;
      vtx_o.world_x <= wrl[0];
      vtx_o.world_y <= wrl[1];
      vtx_o.world_z <= wrl[2];
      vtx_o.normal_x <= nrm_s_q[0];
      vtx_o.normal_y <= nrm_s_q[1];
      vtx_o.normal_z <= nrm_s_q[2];
      vtx_o.red <= r_s_q;
      vtx_o.green <= g_s_q;
      vtx_o.blue <= 8'd0;
      vtx_o.opacity <= a_s_q;
      vtx_o.last <= (vn_s_q == 5'(obvg_pkg::NumVerts - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
      v_s_q <= 1'b0;
      v_o_q <= 1'b0;
    end else if (en_i) begin
      v_p_q <= valid_i;
      v_s_q <= v_p_q;
      v_o_q <= v_s_q;
    end
  end
  assign valid_o = v_o_q;

  `OBVG_ASSERT_NXT(a_valid_moves, clk_i, rst_ni, en_i && valid_i, v_p_q)
  `OBVG_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !en_i, $stable(v_o_q) && $stable(v_s_q))
  `OBVG_ASSERT_IMP(a_blue_zero, clk_i, rst_ni, v_o_q, vtx_o.blue == 8'd0)
endmodule
`default_nettype wire

[sv/oriented_box_vertex_generator_core.sv]
// Top level of the oriented box vertex generator: sequencer, APB registers.
// Depends on obvg_pkg, obvg_types_pkg, obvg_if, obvg_matrix, obvg_vertex and the assertion header.
//
//  channel  dir  payload      words per box
//  box_in   in   box_t        1
//  vtx_out  out  vertex_t     24
//  apb      in   alpha regs   -
//
// The vertex sequencer issues one vertex per cycle while the pipe is not stalled.
// From a taken box word to its first vertex valid: 2 matrix stages,
// 1 sequencer register, 3 vertex stages.
// The next box enters the matrix pipe while the last one still issues, so
// vertices flow without gaps. Whole pipe advances only when the output
// register is empty or being taken; a stall freezes every stage.
// Reset (async, active low) clears valid bits and counter, and sets the
// alpha regs to 255 (highlight) and 77 (default).
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_vertex_generator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  obvg_if.sink      box_in,
  obvg_if.source    vtx_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  `include "oriented_box_vertex_generator_core_assert.svh"

  logic [7:0] hi_alpha_q, def_alpha_q;
  logic       wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_alpha_q <= obvg_pkg::HiAlphaRst;
      def_alpha_q <= obvg_pkg::DefAlphaRst;
    end else if (wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == obvg_pkg::RegHiAlpha) hi_alpha_q <= pwdata[7:0];
      else def_alpha_q <= pwdata[7:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2] == obvg_pkg::RegHiAlpha) prdata = {24'd0, hi_alpha_q};
      else prdata = {24'd0, def_alpha_q};
    end
  end

  // global enable: output register free or draining
  logic en;
  logic vout;
  assign en = !vout || vtx_out.ready;

  // matrix pipe: two stages with valid bits
  logic m1_q, m2_q;
  obvg_pkg::mat_t       mat;
  obvg_types_pkg::box_t mbox;
  logic                 take;   // sequencer takes the matrix stage output
  logic [4:0]           cnt_q;
  logic                 busy_q;
  logic                 m_en;
  // matrix pipe moves when the global enable is up and stage 2 is empty or the sequencer loads it
  assign m_en = en && (!m2_q || take);
  assign box_in.ready = m_en;

  obvg_matrix u_mat (
    .clk_i, .en_i(m_en), .box_i(box_in.data), .mat_o(mat), .box_o(mbox)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= 1'b0;
      m2_q <= 1'b0;
    end else if (m_en) begin
      m1_q <= box_in.valid;
      m2_q <= m1_q;
    end
  end

  // sequencer: holds one box, counts its 24 vertices
  obvg_pkg::mat_t       smat_q;
  obvg_types_pkg::box_t sbox_q;
  logic                 fin;
  assign fin = busy_q && cnt_q == 5'(obvg_pkg::NumVerts - 1);
  assign take = m2_q && (!busy_q || fin);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 5'd0;
    end else if (en) begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd0;
      end else if (fin) begin
        busy_q <= 1'b0;
        cnt_q <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en && take) begin
      smat_q <= mat;
      sbox_q <= mbox;
    end
  end

  obvg_types_pkg::vertex_t vtx;
  obvg_vertex u_vtx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(busy_q), .vnum_i(cnt_q), .mat_i(smat_q),
    .box_i(sbox_q), .hi_alpha_i(hi_alpha_q), .def_alpha_i(def_alpha_q),
    .valid_o(vout), .vtx_o(vtx)
  );
  assign vtx_out.valid = vout;
  assign vtx_out.data = vtx;

  `OBVG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, busy_q, cnt_q < 5'(obvg_pkg::NumVerts))
  `OBVG_ASSERT_NXT(a_take_starts, clk_i, rst_ni, en && take, busy_q && cnt_q == 5'd0)
  `OBVG_ASSERT_IMP(a_last_is_23, clk_i, rst_ni, vout && vtx.last,
                   vtx.vertex_number == 5'(obvg_pkg::NumVerts - 1))
endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for oriented_box_vertex_generator_core: boxes in, 24 vertices out.
// Depends on obvg_pkg, obvg_types_pkg, obvg_if and the core RTL.
`timescale 1ns / 1ps
module testbench;
  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  obvg_if #(.payload_t(obvg_types_pkg::box_t))    box_ch ();
  obvg_if #(.payload_t(obvg_types_pkg::vertex_t)) vtx_ch ();

  oriented_box_vertex_generator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_in (box_ch.sink),
    .vtx_out(vtx_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // local copy of the alpha registers
  logic [7:0] hi_alpha_q;
  logic [7:0] def_alpha_q;

  obvg_types_pkg::vertex_t pending_verts[$];
  int      fail_count;
  bit      stall_random;

  // corner per face slot, faces -z +z -x +x +y -y
  localparam int FaceCorner[24] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 4, 7, 3,
                                    1, 5, 6, 2, 3, 7, 6, 2, 0, 4, 5, 1};
  localparam int FaceAxis[6] = '{2, 2, 0, 0, 1, 1};
  localparam int FaceDir[6]  = '{-1, 1, -1, 1, 1, -1};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half up, arithmetic shift
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // expected 24 vertices of one box
  task automatic predict_box_vertices(input obvg_types_pkg::box_t b);
    longint m[3][3];
    longint w, x, y, z, one, acc;
    longint ctr[3];
    longint sz[3];
    int     sg[3];
    int     c, f;
    obvg_types_pkg::vertex_t v;
    w = b.quat_w; x = b.quat_x; y = b.quat_y; z = b.quat_z;
    one = longint'(1) << 28;
    ctr[0] = b.centre_x; ctr[1] = b.centre_y; ctr[2] = b.centre_z;
    sz[0] = b.size_x; sz[1] = b.size_y; sz[2] = b.size_z;
    m[0][0] = one - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = one - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = sat(m[i][j], -(longint'(1) << 30), longint'(1) << 30);
    for (int n = 0; n < 24; n++) begin
      f = n / 4;
      c = FaceCorner[n];
      sg[0] = (c == 1 || c == 2 || c == 5 || c == 6) ? 1 : -1;
      sg[1] = (c == 2 || c == 3 || c == 6 || c == 7) ? 1 : -1;
      sg[2] = (c >= 4) ? 1 : -1;
      v.vertex_number = 5'(n);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += m[i][j] * (sz[j] * sg[j]);
        acc = sat(ctr[i] + rnd_shift(acc, 29), -64'sd2147483648, 64'sd2147483647);
        case (i)
          0: v.world_x = 32'(acc);
          1: v.world_y = 32'(acc);
          default: v.world_z = 32'(acc);
        endcase
        acc = sat(rnd_shift(m[i][FaceAxis[f]] * FaceDir[f], 14), -32768, 32767);
        case (i)
          0: v.normal_x = 16'(acc);
          1: v.normal_y = 16'(acc);
          default: v.normal_z = 16'(acc);
        endcase
      end
      v.red     = b.selected ? 8'd255 : 8'd217;
      v.green   = b.selected ? 8'd217 : 8'd191;
      v.blue    = 8'd0;
      v.opacity = b.selected ? hi_alpha_q : def_alpha_q;
      v.last    = (n == 23);
      pending_verts.insert(pending_verts.size(), v);
    end
  endtask

  // one APB write: setup, then access, then idle
  task automatic write_alpha_reg(input logic [0:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == obvg_pkg::RegHiAlpha) hi_alpha_q = val;
    else def_alpha_q = val;
    @(posedge clk_i);
  endtask

  // send one box word, after a random gap when stall_random is set; valid stays up for a gapless next word
  task automatic send_box(input obvg_types_pkg::box_t b);
    int gap;
    gap = stall_random ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    box_ch.valid <= 1'b1;
    box_ch.data  <= b;
    @(posedge clk_i);
    while (!box_ch.ready) @(posedge clk_i);
    predict_box_vertices(b);
  endtask

  task automatic wait_drained();
    box_ch.valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic obvg_types_pkg::box_t rand_box(input bit wide);
    obvg_types_pkg::box_t b;
    b.centre_x = wide ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    b.centre_y = wide ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    b.centre_z = wide ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    b.size_x   = wide ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    b.size_y   = wide ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    b.size_z   = wide ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    if ($urandom_range(0, 4) == 0) begin
      // non-unit, full range of the 16-bit fields
      b.quat_w = 16'($urandom); b.quat_x = 16'($urandom);
      b.quat_y = 16'($urandom); b.quat_z = 16'($urandom);
    end else begin
      b.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      b.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      b.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      b.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    b.selected = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // checker: compare each taken vertex with the oldest prediction
  always @(posedge clk_i) begin
    obvg_types_pkg::vertex_t e;
    obvg_types_pkg::vertex_t a;
    if (rst_ni && vtx_ch.valid && vtx_ch.ready) begin
      a = vtx_ch.data;
      if (pending_verts.size() == 0) begin
        $error("vertex with nothing expected");
        fail_count++;
      end else begin
        e = pending_verts.pop_front();
        if (a.vertex_number !== e.vertex_number) begin
          $error("vertex_number exp %0d got %0d", e.vertex_number, a.vertex_number); fail_count++; end
        if (a.world_x !== e.world_x) begin
          $error("world_x exp %0d got %0d", e.world_x, a.world_x); fail_count++; end
        if (a.world_y !== e.world_y) begin
          $error("world_y exp %0d got %0d", e.world_y, a.world_y); fail_count++; end
        if (a.world_z !== e.world_z) begin
          $error("world_z exp %0d got %0d", e.world_z, a.world_z); fail_count++; end
        if (a.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, a.normal_x); fail_count++; end
        if (a.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, a.normal_y); fail_count++; end
        if (a.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, a.normal_z); fail_count++; end
        if (a.red !== e.red) begin
          $error("red exp %0d got %0d", e.red, a.red); fail_count++; end
        if (a.green !== e.green) begin
          $error("green exp %0d got %0d", e.green, a.green); fail_count++; end
        if (a.blue !== e.blue) begin
          $error("blue exp %0d got %0d", e.blue, a.blue); fail_count++; end
        if (a.opacity !== e.opacity) begin
          $error("opacity exp %0d got %0d", e.opacity, a.opacity); fail_count++; end
        if (a.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, a.last); fail_count++; end
      end
    end
  end

  // receiver: random stall per word, none when stall_random is off
  initial begin
    int hold;
    vtx_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = stall_random ? $urandom_range(0, 10) : 0;
      if (hold != 0) begin
        vtx_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      vtx_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!vtx_ch.valid) @(posedge clk_i);
    end
  end

  // directed: extremes, unit rotations, non-unit and saturating cases
  task automatic test_directed();
    obvg_types_pkg::box_t b;
    stall_random = 1'b0;
    b = '0; b.quat_w = 16'sd16384; b.size_x = 31'h10000;
    b.size_y = 31'h20000; b.size_z = 31'h30000;
    send_box(b);
    b.selected = 1'b1; b.quat_w = 16'sd0; b.quat_x = 16'sd16384; send_box(b);
    b.quat_x = 16'sd0; b.quat_y = -16'sd16384; send_box(b);
    b.quat_y = 16'sd0; b.quat_z = 16'sd16384; b.selected = 1'b0; send_box(b);
    b.quat_z = 16'sd11585; b.quat_w = 16'sd11585; send_box(b);
    // position overflow both ways
    b.centre_x = 32'h7FFFFFFF; b.centre_y = 32'h80000000; b.centre_z = 32'h7FFFFFFF;
    b.size_x = 31'h7FFFFFFF; b.size_y = 31'h7FFFFFFF; b.size_z = 31'h7FFFFFFF;
    send_box(b);
    // non-unit quaternion, matrix and normal saturation
    b.quat_w = 16'h7FFF; b.quat_x = 16'h8000; b.quat_y = 16'h7FFF; b.quat_z = 16'h8000;
    b.selected = 1'b1; send_box(b);
    b.quat_w = 16'hFFFF; b.quat_x = 16'h0001; b.quat_y = 16'h4000; b.quat_z = 16'hC000;
    b.centre_x = 32'h80000000; b.size_y = 31'h0; send_box(b);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    stall_random = 1'b1;
    for (int k = 0; k < count; k++) begin
      send_box(rand_box($urandom_range(0, 3) == 0));
      if (k == count / 2) wait_drained();   // hold off until all vertices are out
    end
    wait_drained();
  endtask

  task automatic test_alpha_settings();
    write_alpha_reg(obvg_pkg::RegHiAlpha, 8'd0);
    write_alpha_reg(obvg_pkg::RegDefAlpha, 8'd255);
    test_random(80);
    write_alpha_reg(obvg_pkg::RegHiAlpha, 8'd255);
    write_alpha_reg(obvg_pkg::RegDefAlpha, 8'd0);
    test_random(80);
    write_alpha_reg(obvg_pkg::RegHiAlpha, 8'($urandom));
    write_alpha_reg(obvg_pkg::RegDefAlpha, 8'($urandom));
    test_random(60);
  endtask

  initial begin
    fail_count   = 0;
    stall_random = 1'b0;
    hi_alpha_q   = obvg_pkg::HiAlphaRst;
    def_alpha_q  = obvg_pkg::DefAlphaRst;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    box_ch.valid = 1'b0;
    box_ch.data  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(80);
    test_alpha_settings();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[oriented_box_vertex_generator_core.f]
+incdir+sv
sv/obvg_pkg.sv
sv/obvg_if.sv
sv/obvg_box_in_t.sv
sv/obvg_matrix.sv
sv/obvg_vertex.sv
sv/oriented_box_vertex_generator_core.sv
test/testbench.sv
